// File: rtl/core/ffr_pkg.sv
// ----------------------------------------------------------------------------
// ffr_pkg
// Types and constants shared by the fixed frame receiver core.
// ----------------------------------------------------------------------------
package ffr_pkg;

  localparam int unsigned POS_W = 5;

  localparam logic [7:0] HEADER_BYTE = 8'hAB;
  localparam logic [7:0] TAIL_BYTE   = 8'hCC;

  // Frame layout, as byte positions within the frame
  localparam logic [POS_W-1:0] MODE_POS   = POS_W'(1);
  localparam logic [POS_W-1:0] FIRST_WORD = POS_W'(2);
  localparam logic [POS_W-1:0] SUMMED_LEN = POS_W'(18);  // also the checksum position
  localparam logic [POS_W-1:0] TAIL_POS   = POS_W'(19);

  localparam int unsigned NUM_WORDS = 8;

  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_BAD_TAIL = 2'd1,
    STATUS_BAD_SUM  = 2'd2
  } ffr_status_t;

  typedef enum logic {
    ST_HUNT    = 1'b0,
    ST_COLLECT = 1'b1
  } ffr_state_t;

  typedef struct packed {
    ffr_status_t        frame_status;
    logic [7:0]         mode_byte;
    logic signed [15:0] x_feedback;
    logic signed [15:0] x_target;
    logic signed [15:0] x_drive;
    logic signed [15:0] x_error;
    logic signed [15:0] y_feedback;
    logic signed [15:0] y_target;
    logic signed [15:0] y_drive;
    logic signed [15:0] y_error;
    logic [31:0]        frames_seen;
    logic [31:0]        check_failures;
  } ffr_result_t;

endpackage

// File: rtl/core/ffr_if.sv
// ----------------------------------------------------------------------------
// ffr_if
// Valid/ready channels of the fixed frame receiver: received bytes and
// decoded frame results.
// ----------------------------------------------------------------------------
interface ffr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffr_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic [7:0]         mode_byte;
  logic signed [15:0] x_feedback;
  logic signed [15:0] x_target;
  logic signed [15:0] x_drive;
  logic signed [15:0] x_error;
  logic signed [15:0] y_feedback;
  logic signed [15:0] y_target;
  logic signed [15:0] y_drive;
  logic signed [15:0] y_error;
  logic [31:0]        frames_seen;
  logic [31:0]        check_failures;

  modport source (
    output valid, output frame_status, output mode_byte,
    output x_feedback, output x_target, output x_drive, output x_error,
    output y_feedback, output y_target, output y_drive, output y_error,
    output frames_seen, output check_failures,
    input ready
  );
  modport sink (
    input valid, input frame_status, input mode_byte,
    input x_feedback, input x_target, input x_drive, input x_error,
    input y_feedback, input y_target, input y_drive, input y_error,
    input frames_seen, input check_failures,
    output ready
  );
endinterface

// File: rtl/core/ffr_parser.sv
// ----------------------------------------------------------------------------
// ffr_parser
// Header hunt, frame byte capture, checksum and frame/error counters.
// Result is combinational from the current state and the byte in hand.
// ----------------------------------------------------------------------------
module ffr_parser import ffr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,       // consume step_byte this cycle
  input  logic [7:0]  step_byte,
  output logic        emit,       // step_byte would finish a frame
  output ffr_result_t result
);

  ffr_state_t       state, state_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [31:0]      frame_count, frame_count_next;
  logic [31:0]      error_count, error_count_next;

  logic [7:0]       mode_reg;
  logic [7:0]       frame_bytes [2:17];

  logic [15:0]      words [NUM_WORDS];
  ffr_status_t      status;

  assign emit = (state == ST_COLLECT) && (byte_position == TAIL_POS);

  // tail check wins over checksum; sum holds (sum - checksum) at the tail
  always_comb begin
    if (step_byte != TAIL_BYTE) begin
      status = STATUS_BAD_TAIL;
    end else if (running_sum != 8'd0) begin
      status = STATUS_BAD_SUM;
    end else begin
      status = STATUS_GOOD;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_HUNT: begin
        if (step_byte == HEADER_BYTE) state_next = ST_COLLECT;
      end
      ST_COLLECT: begin
        if (byte_position == TAIL_POS) state_next = ST_HUNT;
      end
      default: state_next = ST_HUNT;
    endcase
  end

  // datapath next values
  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    frame_count_next   = frame_count;
    error_count_next   = error_count;
    unique case (state)
      ST_HUNT: begin
        if (step_byte == HEADER_BYTE) begin
          byte_position_next = POS_W'(1);
          running_sum_next   = step_byte;
        end
      end
      ST_COLLECT: begin
        if (byte_position < SUMMED_LEN) begin
          running_sum_next   = running_sum + step_byte;
          byte_position_next = byte_position + POS_W'(1);
        end else if (byte_position == SUMMED_LEN) begin
          running_sum_next   = running_sum - step_byte;
          byte_position_next = byte_position + POS_W'(1);
        end else begin
          byte_position_next = '0;
          running_sum_next   = '0;
          frame_count_next   = frame_count + 32'd1;
          if (status != STATUS_GOOD) error_count_next = error_count + 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_HUNT;
      byte_position <= '0;
      running_sum   <= '0;
      frame_count   <= '0;
      error_count   <= '0;
    end else if (step) begin
      state         <= state_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      frame_count   <= frame_count_next;
      error_count   <= error_count_next;
    end
  end

  // frame byte capture, no reset: every byte read is written earlier in the frame
  always_ff @(posedge clk) begin
    if (step && (state == ST_COLLECT)) begin
      if (byte_position == MODE_POS) mode_reg <= step_byte;
      for (int k = 2; k <= 17; k++) begin
        if (byte_position == POS_W'(k)) frame_bytes[k] <= step_byte;
      end
    end
  end

  // big-endian 16-bit values
  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      words[k] = {frame_bytes[int'(FIRST_WORD) + 2*k], frame_bytes[int'(FIRST_WORD) + 2*k + 1]};
    end
  end

  // result; bad frames report zero data fields
  always_comb begin
    result                = '0;
    result.frame_status   = status;
    result.frames_seen    = frame_count_next;
    result.check_failures = error_count_next;
    if (status == STATUS_GOOD) begin
      result.mode_byte  = mode_reg;
      result.x_feedback = words[0];
      result.x_target   = words[1];
      result.x_drive    = words[2];
      result.x_error    = words[3];
      result.y_feedback = words[4];
      result.y_target   = words[5];
      result.y_drive    = words[6];
      result.y_error    = words[7];
    end
  end

endmodule

// File: rtl/core/ffr_out_reg.sv
// ----------------------------------------------------------------------------
// ffr_out_reg
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module ffr_out_reg import ffr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  ffr_result_t data,
  output logic        free,     // register can take a result this cycle
  ffr_result_if.source res
);

  logic        valid;
  ffr_result_t held;

  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= data;
  end

  assign res.valid          = valid;
  assign res.frame_status   = held.frame_status;
  assign res.mode_byte      = held.mode_byte;
  assign res.x_feedback     = held.x_feedback;
  assign res.x_target       = held.x_target;
  assign res.x_drive        = held.x_drive;
  assign res.x_error        = held.x_error;
  assign res.y_feedback     = held.y_feedback;
  assign res.y_target       = held.y_target;
  assign res.y_drive        = held.y_drive;
  assign res.y_error        = held.y_error;
  assign res.frames_seen    = held.frames_seen;
  assign res.check_failures = held.check_failures;

endmodule

// File: rtl/core/fixed_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// fixed_frame_receiver_core
// Byte-wise receiver for fixed 20-byte frames with an 8-bit sum check.
// ----------------------------------------------------------------------------
// One received byte per item, one byte per cycle sustained unless a tail
// byte waits for the result register. Bytes are dropped until the header
// 0xAB; the header and the next 19 bytes form a frame (mode, eight
// big-endian signed 16-bit values, sum of bytes 0..17, tail 0xCC). The
// 20th byte produces one result item carrying status (good / bad tail /
// bad checksum, tail check first), the decoded fields (zero for a bad
// frame) and wrapping 32-bit counts of frames and of failed frames. A bad
// frame yields only its status and counts, and the hunt restarts on the
// next byte. The tail byte is accepted into the input register, and the
// parser logic then loads the result register from it once that register
// is free. Only the tail byte waits for the result register to empty;
// while it waits it holds the input register and the input stalls.
// ----------------------------------------------------------------------------
module fixed_frame_receiver_core import ffr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ffr_byte_if.sink     rx_ch,
  ffr_result_if.source res_ch
);

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;

  // parser / result register handshake
  logic        emit;
  logic        out_free;
  logic        s1_advance;
  logic        out_load;
  ffr_result_t result;

  // a byte moves on unless it finishes a frame and the result slot is busy
  assign s1_advance = !emit || out_free;
  assign out_load   = s1_valid && emit && out_free;
  assign rx_ch.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_ch.valid && rx_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ch.valid && rx_ch.ready) s1_byte <= rx_ch.rx_byte;
  end

  ffr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_valid && s1_advance),
    .step_byte (s1_byte),
    .emit      (emit),
    .result    (result)
  );

  ffr_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .data (result),
    .free (out_free),
    .res  (res_ch)
  );

  // a stalled tail byte stays in the input register
  a_tail_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_byte)))
    else $error("tail byte lost while result slot busy");

  // a new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!res_ch.valid || res_ch.ready))
    else $error("pending result overwritten");

  // bad frames carry zero data fields
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && (result.frame_status != STATUS_GOOD)) |->
      (result.mode_byte == 8'd0 && result.x_feedback == 16'sd0 &&
       result.y_error == 16'sd0))
    else $error("bad frame carries data");

  // every loaded result shows up on the channel next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> res_ch.valid)
    else $error("loaded result not presented");

endmodule
